// ===== rtl/fpfa_pkg.sv =====
// ---------------------------------------------------------------------------
// fpfa_pkg
// shared types and constants of the fixed partition fit allocator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpfa_pkg;

    localparam int PARTS  = 16;
    localparam int IDX_W  = 4;
    localparam int SIZE_W = 16;
    localparam int CNT_W  = 5;
    localparam int MODE_W = 2;
    localparam int CFG_W  = 4;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_ALLOC   = 2'd1,
        REQ_RESTORE = 2'd2,
        REQ_READ    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_BEST  = 2'd1,
        MODE_WORST = 2'd2,
        MODE_SPARE = 2'd3
    } fit_mode_t;

    typedef enum logic [2:0] {
        ST_PLACED   = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_LOADED   = 3'd2,
        ST_RESTORED = 3'd3,
        ST_READ     = 3'd4,
        ST_BADIDX   = 3'd5
    } status_t;

    typedef enum logic [CFG_W-1:0] {
        CFG_FIT_MODE   = 4'd0,
        CFG_PART_COUNT = 4'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_LOAD    = 2'd1,
        OP_RESTORE = 2'd2,
        OP_COMMIT  = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EMIT = 2'd2
    } state_t;

    typedef struct packed {
        cell_op_t op;
        idx_t     idx;
        size_t    size;
    } cell_ctl_t;

    typedef struct packed {
        logic  valid;
        logic  found;
        idx_t  idx;
        size_t size;
    } cand_t;

endpackage

// ===== rtl/fixed_partition_fit_allocator.sv =====
// ---------------------------------------------------------------------------
// fixed_partition_fit_allocator
// partition table with first, best and worst fit allocation over a cell chain
// ---------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  req_type, part_index, req_size
// out      output     out_valid/out_stall status, slot_index, free_size
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// load, read and restore register their result on accept and go straight to the emit state
// allocate first scans: the candidate walks the cell chain, one cell a cycle
// one transaction in flight; a new one is accepted while the result waits on out_stall
// reset clears all sizes and sets first fit with 16 partitions
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_partition_fit_allocator
    import fpfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [IDX_W-1:0]  part_index,
    input  logic [SIZE_W-1:0] req_size,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [IDX_W-1:0]  slot_index,
    output logic [SIZE_W-1:0] free_size,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_index,
    input  logic [CNT_W-1:0]  cfg_data
);

    state_t    state_reg;
    state_t    state_next;
    fit_mode_t mode_reg;
    cnt_t      count_reg;
    size_t     req_reg;
    size_t     req_next;
    status_t   res_status_reg;
    status_t   res_status_next;
    idx_t      res_idx_reg;
    idx_t      res_idx_next;
    size_t     res_size_reg;
    size_t     res_size_next;
    logic      out_valid_reg;
    status_t   out_status_reg;
    idx_t      out_idx_reg;
    size_t     out_size_reg;
    logic      in_acc;
    logic      emit_go;
    logic      idx_ok;
    cell_ctl_t ctl;
    cand_t     chain [PARTS+1];
    size_t     rem_vec [PARTS];
    logic      active_vec [PARTS];
    logic [PARTS-1:0] tok_vec;
    cand_t     scan_res;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign idx_ok   = ({1'b0, part_index} < count_reg);
    assign scan_res = chain[PARTS];

    assign chain[0] = '{valid: in_acc && (req_type_t'(req_type) == REQ_ALLOC),
                        found: 1'b0, idx: '0, size: '0};

    for (genvar k = 0; k < PARTS; k++)
    begin : g_cell
        assign active_vec[k] = ({1'b0, IDX_W'(k)} < count_reg);
        assign tok_vec[k]    = chain[k+1].valid;

        // the first cell sees the request in the accepting cycle
        fpfa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .own_idx  (IDX_W'(k)),
            .active   (active_vec[k]),
            .mode     (mode_reg),
            .req      ((k == 0) ? req_next : req_reg),
            .cand_in  (chain[k]),
            .cand_out (chain[k+1]),
            .rem      (rem_vec[k])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (req_type_t'(req_type) == REQ_ALLOC) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN:
            begin
                if (scan_res.valid)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // cell control and pending result
    always_comb
    begin
        ctl             = '{op: OP_NONE, idx: '0, size: '0};
        req_next        = req_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_size_next   = res_size_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    req_next = req_size;
                    case (req_type_t'(req_type))
                        REQ_LOAD:
                        begin
                            res_idx_next = part_index;
                            if (idx_ok)
                            begin
                                ctl             = '{op: OP_LOAD, idx: part_index,
                                                    size: req_size};
                                res_status_next = ST_LOADED;
                                res_size_next   = req_size;
                            end
                            else
                            begin
                                res_status_next = ST_BADIDX;
                                res_size_next   = '0;
                            end
                        end
                        REQ_READ:
                        begin
                            res_idx_next = part_index;
                            if (idx_ok)
                            begin
                                res_status_next = ST_READ;
                                res_size_next   = rem_vec[part_index];
                            end
                            else
                            begin
                                res_status_next = ST_BADIDX;
                                res_size_next   = '0;
                            end
                        end
                        REQ_RESTORE:
                        begin
                            ctl             = '{op: OP_RESTORE, idx: '0, size: '0};
                            res_status_next = ST_RESTORED;
                            res_idx_next    = '0;
                            res_size_next   = '0;
                        end
                        default:
                        begin
                            res_status_next = ST_NOFIT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_res.valid)
                begin
                    if (scan_res.found)
                    begin
                        ctl             = '{op: OP_COMMIT, idx: scan_res.idx,
                                            size: scan_res.size - req_reg};
                        res_status_next = ST_PLACED;
                        res_idx_next    = scan_res.idx;
                        res_size_next   = scan_res.size - req_reg;
                    end
                    else
                    begin
                        res_status_next = ST_NOFIT;
                        res_idx_next    = '0;
                        res_size_next   = '0;
                    end
                end
            end
            default:
            begin
                ctl = '{op: OP_NONE, idx: '0, size: '0};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_FIRST;
            count_reg     <= CNT_W'(PARTS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_FIT_MODE:   mode_reg  <= fit_mode_t'(cfg_data[MODE_W-1:0]);
                    CFG_PART_COUNT: count_reg <= cfg_data;
                    default:        mode_reg  <= mode_reg;
                endcase
            end
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_size_reg   <= res_size_next;
        if (emit_go)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
            out_size_reg   <= res_size_reg;
        end
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot_index = out_idx_reg;
    assign free_size  = out_size_reg;

    // at most one candidate travels the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one scan candidate in the chain");

    // the scan only completes while an allocate is in progress
    a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.valid |-> state_reg == S_SCAN)
        else $error("scan result outside scan state");

    // a chosen partition always covers the request
    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_res.valid && scan_res.found) |-> scan_res.size >= req_reg)
        else $error("chosen partition smaller than request");

    // a placed result never leaves a partition outside the active range
    a_pick_active: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_res.valid && scan_res.found) |-> {1'b0, scan_res.idx} < count_reg)
        else $error("inactive partition chosen");

endmodule

// ===== rtl/fpfa_cell.sv =====
// ---------------------------------------------------------------------------
// fpfa_cell
// one partition: remaining and original size, and one stage of the fit scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpfa_cell
    import fpfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  idx_t      own_idx,
    input  logic      active,
    input  fit_mode_t mode,
    input  size_t     req,
    input  cand_t     cand_in,
    output cand_t     cand_out,
    output size_t     rem
);

    size_t rem_reg;
    size_t rem_next;
    size_t orig_reg;
    size_t orig_next;
    cand_t cand_reg;
    cand_t cand_next;
    logic  fits;
    logic  take;

    always_comb
    begin
        rem_next  = rem_reg;
        orig_next = orig_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                if (ctl.idx == own_idx)
                begin
                    rem_next  = ctl.size;
                    orig_next = ctl.size;
                end
            end
            OP_RESTORE:
            begin
                rem_next = orig_reg;
            end
            OP_COMMIT:
            begin
                if (ctl.idx == own_idx)
                begin
                    rem_next = ctl.size;
                end
            end
            default:
            begin
                rem_next = rem_reg;
            end
        endcase
    end

    // candidate handed on to the next cell
    always_comb
    begin
        fits = active && (rem_reg >= req);
        take = 1'b0;
        if (fits)
        begin
            if (!cand_in.found)
            begin
                take = 1'b1;
            end
            else if (mode == MODE_BEST)
            begin
                take = rem_reg < cand_in.size;
            end
            else if (mode == MODE_WORST)
            begin
                take = rem_reg > cand_in.size;
            end
        end
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found = 1'b1;
            cand_next.idx   = own_idx;
            cand_next.size  = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            orig_reg <= '0;
            cand_reg <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            orig_reg <= orig_next;
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;
    assign rem      = rem_reg;

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the fixed partition fit allocator: a queue-fed
// driver and a monitor compare every result against an in-bench model of
// the partition table under first, best and worst fit, with random idling
// on both channels and settings changed between phases
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import fpfa_pkg::*;

    localparam logic [CFG_W-1:0] CFG_UNUSED = 4'd9;

    typedef struct packed {
        req_type_t kind;
        idx_t      slot;
        size_t     amount;
    } request_t;

    typedef struct packed {
        status_t st;
        idx_t    slot;
        size_t   left;
    } reply_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [1:0]        req_type   = '0;
    logic [IDX_W-1:0]  part_index = '0;
    logic [SIZE_W-1:0] req_size   = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [2:0]        status;
    logic [IDX_W-1:0]  slot_index;
    logic [SIZE_W-1:0] free_size;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_index  = '0;
    logic [CNT_W-1:0]  cfg_data   = '0;

    // table model
    size_t     free_left [PARTS];
    size_t     full_size [PARTS];
    fit_mode_t policy;
    cnt_t      count_reg;

    request_t pending_requests [$];
    reply_t   replies_due [$];
    request_t on_wire;
    reply_t   want;
    int       idle_pct   = 7;
    int       mismatches = 0;

    fixed_partition_fit_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .part_index (part_index),
        .req_size   (req_size),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot_index (slot_index),
        .free_size  (free_size),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic reply_t serve_request(input request_t r);
        reply_t res;
        int     active;
        int     j;
        int     pick;
        bit     hit;
        active = (count_reg > PARTS) ? PARTS : int'(count_reg);
        res    = '0;
        hit    = 1'b0;
        pick   = 0;
        case (r.kind)
            REQ_LOAD, REQ_READ:
            begin
                res.slot = r.slot;
                if (int'(r.slot) >= active)
                begin
                    res.st = ST_BADIDX;
                end
                else if (r.kind == REQ_LOAD)
                begin
                    free_left[r.slot] = r.amount;
                    full_size[r.slot] = r.amount;
                    res.st   = ST_LOADED;
                    res.left = r.amount;
                end
                else
                begin
                    res.st   = ST_READ;
                    res.left = free_left[r.slot];
                end
            end
            REQ_RESTORE:
            begin
                for (j = 0; j < PARTS; j++)
                    free_left[j] = full_size[j];
                res.st = ST_RESTORED;
            end
            default:
            begin
                for (j = 0; j < active; j++)
                begin
                    if (free_left[j] >= r.amount)
                    begin
                        if (!hit)
                        begin
                            hit  = 1'b1;
                            pick = j;
                            if (policy != MODE_BEST && policy != MODE_WORST)
                                break;
                        end
                        else if (policy == MODE_BEST && free_left[j] < free_left[pick])
                            pick = j;
                        else if (policy == MODE_WORST && free_left[j] > free_left[pick])
                            pick = j;
                    end
                end
                if (!hit)
                begin
                    res.st = ST_NOFIT;
                end
                else
                begin
                    free_left[pick] = free_left[pick] - r.amount;
                    res.st   = ST_PLACED;
                    res.slot = idx_t'(pick);
                    res.left = free_left[pick];
                end
            end
        endcase
        return res;
    endfunction

    function automatic size_t draw_amount(input int narrow_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < narrow_pct)
            return size_t'($urandom_range(255));
        else if (roll < narrow_pct + 30)
            return size_t'($urandom_range(4095));
        else if (roll < 90)
            return size_t'($urandom);
        else
            return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic request_t make_request(input int active);
        request_t r;
        int       roll;
        roll     = $urandom_range(99);
        r.kind   = req_type_t'($urandom_range(3));
        r.slot   = idx_t'($urandom_range(PARTS - 1));
        r.amount = size_t'($urandom);
        if (roll < 5)
            return r;
        if (roll < 30)
        begin
            r.kind   = REQ_LOAD;
            r.amount = draw_amount(10);
        end
        else if (roll < 75)
        begin
            r.kind   = REQ_ALLOC;
            r.amount = draw_amount(40);
        end
        else if (roll < 80)
        begin
            r.kind = REQ_RESTORE;
        end
        else
        begin
            r.kind = REQ_READ;
        end
        if (active > 0 && (r.kind == REQ_LOAD || r.kind == REQ_READ))
            r.slot = idx_t'($urandom_range(active - 1));
        return r;
    endfunction

    task automatic queue_request(input req_type_t kind, input idx_t slot, input size_t amount);
        request_t r;
        r.kind   = kind;
        r.slot   = slot;
        r.amount = amount;
        pending_requests.push_back(r);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || replies_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FIT_MODE)
            policy = fit_mode_t'(val[MODE_W-1:0]);
        else if (idx == CFG_PART_COUNT)
            count_reg = val;
    endtask

    task automatic set_policy(input fit_mode_t mode, input cnt_t count);
        write_reg(CFG_FIT_MODE, cnt_t'(mode));
        write_reg(CFG_PART_COUNT, count);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                replies_due.push_back(serve_request(on_wire));
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    on_wire = pending_requests.pop_front();
                    in_valid   <= 1'b1;
                    req_type   <= on_wire.kind;
                    part_index <= on_wire.slot;
                    req_size   <= on_wire.amount;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("unexpected result: status %0d slot_index %0d free_size %0d",
                           status, slot_index, free_size);
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status expected %0d actual %0d", want.st, status);
                        mismatches++;
                    end
                    if (slot_index !== want.slot)
                    begin
                        $error("slot_index expected %0d actual %0d", want.slot, slot_index);
                        mismatches++;
                    end
                    if (free_size !== want.left)
                    begin
                        $error("free_size expected %0d actual %0d", want.left, free_size);
                        mismatches++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    initial
    begin
        int k;
        int phase;
        int items;
        int active;
        for (k = 0; k < PARTS; k++)
        begin
            free_left[k] = '0;
            full_size[k] = '0;
        end
        policy    = MODE_FIRST;
        count_reg = cnt_t'(PARTS);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: first fit over all partitions
        queue_request(REQ_READ,    4'd15, 16'd0);
        queue_request(REQ_ALLOC,   4'd0,  16'd0);
        queue_request(REQ_ALLOC,   4'd0,  16'd1);
        queue_request(REQ_LOAD,    4'd0,  16'hFFFF);
        queue_request(REQ_LOAD,    4'd15, 16'h5A5A);
        queue_request(REQ_LOAD,    4'd7,  16'h8000);
        queue_request(REQ_ALLOC,   4'd3,  16'hFFFF);
        queue_request(REQ_ALLOC,   4'd0,  16'h8000);
        queue_request(REQ_RESTORE, 4'd0,  16'd0);
        queue_request(REQ_READ,    4'd0,  16'd0);
        queue_request(REQ_READ,    4'd7,  16'd0);
        wait_idle();

        // best fit, ties and out-of-range indices
        set_policy(MODE_BEST, 5'd4);
        queue_request(REQ_LOAD,  4'd0,  16'd50);
        queue_request(REQ_LOAD,  4'd1,  16'd30);
        queue_request(REQ_LOAD,  4'd2,  16'd30);
        queue_request(REQ_LOAD,  4'd3,  16'd70);
        queue_request(REQ_ALLOC, 4'd0,  16'd25);
        queue_request(REQ_LOAD,  4'd4,  16'd99);
        queue_request(REQ_READ,  4'd12, 16'd0);
        queue_request(REQ_ALLOC, 4'd0,  16'd71);
        wait_idle();

        write_reg(CFG_FIT_MODE, cnt_t'(MODE_WORST));
        queue_request(REQ_ALLOC, 4'd0, 16'd10);
        queue_request(REQ_ALLOC, 4'd0, 16'd0);
        wait_idle();

        // no active partition, spare mode
        set_policy(MODE_SPARE, 5'd0);
        queue_request(REQ_ALLOC, 4'd0, 16'd0);
        queue_request(REQ_LOAD,  4'd0, 16'd1);
        queue_request(REQ_READ,  4'd0, 16'd0);
        wait_idle();

        // count beyond the table saturates, spare mode acts as first fit
        write_reg(CFG_PART_COUNT, 5'd31);
        queue_request(REQ_ALLOC, 4'd0, 16'd40);
        wait_idle();

        for (phase = 0; phase < 8; phase++)
        begin
            items = 270;
            case (phase)
                0: set_policy(MODE_FIRST, 5'd16);
                1: set_policy(MODE_BEST, 5'd1);
                2:
                begin
                    set_policy(MODE_WORST, 5'd31);
                    write_reg(CFG_UNUSED, cnt_t'($urandom));
                end
                3:
                begin
                    set_policy(MODE_SPARE, 5'd0);
                    items = 50;
                end
                default:
                begin
                    set_policy(fit_mode_t'($urandom_range(3)), cnt_t'($urandom_range(31, 1)));
                    if (phase == 6)
                        write_reg(4'd15, cnt_t'($urandom));
                end
            endcase
            idle_pct = (phase == 4) ? 0 : 7;
            active   = (count_reg > PARTS) ? PARTS : int'(count_reg);
            for (k = 0; k < items; k++)
            begin
                // hold the sender until the table has settled
                if (phase == 5 && k == items / 2)
                    wait_idle();
                pending_requests.push_back(make_request(active));
            end
            wait_idle();
        end

        idle_pct = 7;
        repeat (PARTS + 4) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
